// ===== src/assert_macros.svh =====
// assertion macros shared by the deframer rtl
// no dependencies; included by modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DPD_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, disabled while in reset
`define DPD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== src/dpd_pkg.sv =====
// package for the debug packet deframer: codes, result type, hex decode
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpd_pkg;

    // framing characters
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;
    localparam logic [7:0] CH_INTR  = 8'h03;

    // result kinds
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_END     = 3'd1;
    localparam logic [2:0] KIND_INTR    = 3'd2;
    localparam logic [2:0] KIND_ACK     = 3'd3;
    localparam logic [2:0] KIND_NAK     = 3'd4;

    // reply codes
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_PLUS = 2'd1;
    localparam logic [1:0] REPLY_MINUS = 2'd2;

    // frame phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_CHK1 = 2'd2;
    localparam logic [1:0] PH_CHK2 = 2'd3;

    typedef struct packed {
        logic [2:0] item_kind;
        logic [7:0] payload_byte;
        logic       checksum_ok;
        logic [1:0] reply_ack;
    } dpd_result_t;

    // bit 4 set when the byte is not a hex digit, else bits 3:0 hold its value
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b0, b[3:0]};
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            r = {1'b0, b[3:0] + 4'd9};
        else
            r = 5'b1_0000;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/dpd_if.sv =====
// channel interfaces for the deframer: received bytes, result items, config
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface dpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpd_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] item_kind;
    logic [7:0] payload_byte;
    logic       checksum_ok;
    logic [1:0] reply_ack;
    modport source (output valid, output item_kind, output payload_byte,
                    output checksum_ok, output reply_ack, input ready);
    modport sink (input valid, input item_kind, input payload_byte,
                  input checksum_ok, input reply_ack, output ready);
endinterface

interface dpd_cfg_if;
    logic valid;
    logic ready;
    logic no_ack_mode;
    modport source (output valid, output no_ack_mode, input ready);
    modport sink (input valid, input no_ack_mode, output ready);
endinterface

`default_nettype wire

// ===== src/dpd_parser.sv =====
// frame state and per-byte decode of the deframer
// depends on dpd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dpd_parser
    import dpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_fire,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        no_ack_mode,
    output logic             res_valid,
    output dpd_result_t      res
);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [3:0] nib_reg, nib_next;
    logic       err_reg, err_next;

    logic [4:0] hex;
    logic       ok;

    always_comb
    begin
        hex        = hex_decode(rx_byte);
        ok         = !err_reg && !hex[4] && ({nib_reg, hex[3:0]} == sum_reg);
        phase_next = phase_reg;
        sum_next   = sum_reg;
        nib_next   = nib_reg;
        err_next   = err_reg;
        res_valid  = 1'b0;
        res        = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == CH_INTR)
                begin
                    res_valid     = 1'b1;
                    res.item_kind = KIND_INTR;
                end
                else if (rx_byte == CH_ACK)
                begin
                    res_valid     = 1'b1;
                    res.item_kind = KIND_ACK;
                end
                else if (rx_byte == CH_NAK)
                begin
                    res_valid     = 1'b1;
                    res.item_kind = KIND_NAK;
                end
                else if (rx_byte == CH_START)
                begin
                    phase_next = PH_DATA;
                    sum_next   = '0;
                    nib_next   = '0;
                    err_next   = 1'b0;
                end
            end
            PH_DATA:
            begin
                if (rx_byte == CH_END)
                    phase_next = PH_CHK1;
                else
                begin
                    sum_next         = sum_reg + rx_byte;
                    res_valid        = 1'b1;
                    res.item_kind    = KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                end
            end
            PH_CHK1:
            begin
                phase_next = PH_CHK2;
                nib_next   = hex[4] ? 4'd0 : hex[3:0];
                err_next   = err_reg | hex[4];
            end
            default:
            begin
                phase_next      = PH_IDLE;
                sum_next        = '0;
                nib_next        = '0;
                err_next        = 1'b0;
                res_valid       = 1'b1;
                res.item_kind   = KIND_END;
                res.checksum_ok = ok;
                res.reply_ack   = no_ack_mode ? REPLY_NONE : (ok ? REPLY_PLUS : REPLY_MINUS);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sum_reg   <= '0;
            nib_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else if (byte_fire)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            nib_reg   <= nib_next;
            err_reg   <= err_next;
        end
    end

    `DPD_ASSERT_NEXT(a_end_returns_idle, clk, rst_n, byte_fire && phase_reg == PH_CHK2, phase_reg == PH_IDLE)
    `DPD_ASSERT_SAME(a_end_only_in_chk2, clk, rst_n, res_valid && res.item_kind == KIND_END, phase_reg == PH_CHK2)
    `DPD_ASSERT_SAME(a_byte_only_payload, clk, rst_n, res_valid && res.item_kind != KIND_PAYLOAD, res.payload_byte == 8'd0)
    `DPD_ASSERT_NEXT(a_sum_cleared_on_end, clk, rst_n, byte_fire && phase_reg == PH_CHK2, sum_reg == 8'd0 && err_reg == 1'b0)

endmodule

`default_nettype wire

// ===== src/debug_packet_deframer_top.sv =====
// top level of the debug packet deframer
// depends on dpd_pkg, dpd_if, dpd_parser and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// channel  role    payload                                          handshake
// rx       sink    rx_byte                                          valid/ready
// res      source  item_kind, payload_byte, checksum_ok, reply_ack  valid/ready
// cfg      sink    no_ack_mode                                      valid/ready, always ready
//
// one byte request per cycle; its result, if any, sits in the output register from
// the cycle after acceptance. the byte decode and frame state update is a single
// short combinational pass from the accepted byte into that register.
// reset clears the frame state, the output valid and no_ack_mode; nothing to sweep.
// rx stalls only while the output register holds a result the sink has not taken.

`include "assert_macros.svh"

module debug_packet_deframer_top
    import dpd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dpd_byte_if.sink    rx,
    dpd_item_if.source  res,
    dpd_cfg_if.sink     cfg
);

    logic        no_ack_reg;
    logic        out_valid_reg, out_valid_next;
    dpd_result_t out_data_reg;

    logic        byte_fire;
    logic        p_valid;
    dpd_result_t p_res;

    // config register; the user must write it only while the block is idle, the block does not enforce this
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            no_ack_reg <= 1'b0;
        else if (cfg.valid)
            no_ack_reg <= cfg.no_ack_mode;
    end

    // a byte can enter whenever the output register is free or draining
    assign rx.ready  = !out_valid_reg || res.ready;
    assign byte_fire = rx.valid && rx.ready;

    dpd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_fire   (byte_fire),
        .rx_byte     (rx.rx_byte),
        .no_ack_mode (no_ack_reg),
        .res_valid   (p_valid),
        .res         (p_res)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (byte_fire)
            out_valid_next = p_valid;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (byte_fire && p_valid)
            out_data_reg <= p_res;
    end

    assign res.valid        = out_valid_reg;
    assign res.item_kind    = out_data_reg.item_kind;
    assign res.payload_byte = out_data_reg.payload_byte;
    assign res.checksum_ok  = out_data_reg.checksum_ok;
    assign res.reply_ack    = out_data_reg.reply_ack;

    `DPD_ASSERT_SAME(a_ack_only_at_end, clk, rst_n, out_valid_reg && out_data_reg.item_kind != KIND_END, out_data_reg.reply_ack == REPLY_NONE)
    `DPD_ASSERT_SAME(a_no_ack_mode_quiet, clk, rst_n, out_valid_reg && no_ack_reg && $stable(no_ack_reg), out_data_reg.reply_ack == REPLY_NONE)
    `DPD_ASSERT_NEXT(a_result_loaded, clk, rst_n, byte_fire && p_valid, out_valid_reg)

endmodule

`default_nettype wire
